// ----- src/vpe_pkg.sv -----
// types and constants shared by the voice pool envelope engine
// no dependencies
package vpe_pkg;

    localparam int LEN_W  = 20;
    localparam int LVL_W  = 16;
    localparam int NOTE_W = 7;
    localparam int FRAC_W = 15;

    localparam logic [LVL_W-1:0] FULL_LEVEL = 16'h8000;

    // configuration register indexes
    localparam logic [1:0] CFG_ATTACK  = 2'd0;
    localparam logic [1:0] CFG_DECAY   = 2'd1;
    localparam logic [1:0] CFG_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        ST_STOPPED = 2'd0,
        ST_ATTACK  = 2'd1,
        ST_DECAY   = 2'd2,
        ST_RELEASE = 2'd3
    } t_stage;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_TRIG = 2'd1,
        REQ_REL  = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_DAT, S_CALC, S_DIV, S_MUL, S_WR, S_EMIT
    } t_bstate;

    typedef enum logic [1:0] {
        PASS_TICK, PASS_SCAN, PASS_TRIG, PASS_REL
    } t_pass;

    typedef struct packed {
        t_stage              stage;
        logic [LEN_W-1:0]    count;
        logic [LVL_W-1:0]    level;
        logic [LVL_W-1:0]    rstart;
        logic [NOTE_W-1:0]   note;
        logic [LVL_W-1:0]    vel;
    } t_voice;

    typedef struct packed {
        t_req                kind;
        logic [NOTE_W-1:0]   note;
        logic [LVL_W-1:0]    vel;
    } t_cmd;

    typedef struct packed {
        logic [3:0]          idx;
        logic                act;
        logic [NOTE_W-1:0]   note;
        logic [LVL_W-1:0]    vel;
        logic [LVL_W-1:0]    level;
        logic [4:0]          rcnt;
        logic                last;
    } t_res;

    typedef struct packed {
        logic [LEN_W-1:0]    attack_len;
        logic [LEN_W-1:0]    decay_len;
        logic [LEN_W-1:0]    rel_len;
    } t_cfg;

endpackage

// ----- src/voice_pool_envelope_engine.sv -----
// voice pool envelope engine: a tick steps each voice through read, calc, divide when needed,
// multiply and write, and output stalls hold it while a result beat waits
// trigger: two ram passes over all voices, a scan and then a write
// release: one ram pass over all voices
// one command at a time in the back end; a two-beat queue takes input meanwhile until full
// reset: synchronous, clears control state and voice valid bits at once, no clearing pass
module voice_pool_envelope_engine #(
    parameter int NUM_VOICES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [6:0]  i_note,
    input  logic [15:0] i_velocity,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_voice_index,
    output logic        o_active,
    output logic [6:0]  o_voice_note,
    output logic [15:0] o_voice_velocity,
    output logic [15:0] o_level,
    output logic [4:0]  o_released_count,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data
);
    import vpe_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    logic  cmd_valid;
    logic  pop;
    t_res  res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_len <= 20'd0;
            r_cfg.decay_len  <= 20'd4800;
            r_cfg.rel_len    <= 20'd4800;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATTACK:  r_cfg.attack_len <= i_cfg_data;
                CFG_DECAY:   r_cfg.decay_len  <= i_cfg_data;
                CFG_RELEASE: r_cfg.rel_len    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_note      (i_note),
        .i_velocity  (i_velocity),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    vpe_back #(
        .NUM_VOICES (NUM_VOICES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (res)
    );

    // result beat fields
    assign o_voice_index    = res.idx;
    assign o_active         = res.act;
    assign o_voice_note     = res.note;
    assign o_voice_velocity = res.vel;
    assign o_level          = res.level;
    assign o_released_count = res.rcnt;
    assign o_last           = res.last;

endmodule

// ----- src/vpe_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module vpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/vpe_div.sv -----
// restoring divider giving the 15-bit fraction (num << 15) / den for num < den
// depends on vpe_pkg
module vpe_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vpe_pkg::LEN_W-1:0]  i_num,
    input  logic [vpe_pkg::LEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [vpe_pkg::FRAC_W-1:0] o_quot
);
    import vpe_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'(FRAC_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [3:0]          r_step;
    logic [LEN_W-1:0]    r_rem;
    logic [LEN_W-1:0]    r_den;
    logic [FRAC_W-1:0]   r_quot;
    logic [LEN_W:0]      rem_sh;
    logic                take;

    // one quotient bit a cycle
    assign rem_sh = {r_rem, 1'b0};
    assign take   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? LEN_W'(rem_sh - {1'b0, r_den}) : LEN_W'(rem_sh);
            r_quot <= {r_quot[FRAC_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- src/vpe_front.sv -----
// front end: takes request beats, drops unknown types, queues commands
// depends on vpe_pkg
module vpe_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [vpe_pkg::NOTE_W-1:0]  i_note,
    input  logic [vpe_pkg::LVL_W-1:0]   i_velocity,
    output logic                        o_cmd_valid,
    output vpe_pkg::t_cmd               o_cmd,
    input  logic                        i_pop
);
    import vpe_pkg::*;

    t_cmd        r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        push;
    t_req        kind;

    // classify the request
    assign kind    = t_req'(i_req_type);
    assign o_ready = r_cnt != 2'd2;
    assign push    = i_valid && o_ready && (kind != REQ_NONE);

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{kind: kind, note: i_note, vel: i_velocity};
        end
    end

    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_q[r_rp];

endmodule

// ----- src/vpe_back.sv -----
// back end: sequences voice passes over the voice ram and drives results
// depends on vpe_pkg, vpe_ram, vpe_div
module vpe_back #(
    parameter int NUM_VOICES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vpe_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  vpe_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output vpe_pkg::t_res o_res
);
    import vpe_pkg::*;

    localparam int VW   = $clog2(NUM_VOICES);
    localparam int RW   = $bits(t_voice) + VW;
    localparam int NREP = (NUM_VOICES < 16) ? NUM_VOICES : 16;
    localparam int CW   = $clog2(NUM_VOICES + 1);
    localparam logic [VW-1:0] LAST_V   = VW'(NUM_VOICES - 1);
    localparam logic [VW-1:0] REP_LAST = VW'(NREP - 1);

    t_bstate            r_state;
    t_bstate            n_state;
    t_pass              r_pass;
    logic [VW-1:0]      r_v;
    t_cmd               r_cmd;
    t_voice             r_rec;
    logic [VW-1:0]      r_age;
    logic [NUM_VOICES-1:0] r_vld;
    logic               r_found;
    logic [VW-1:0]      r_sel;
    logic [VW-1:0]      r_old;
    logic [VW-1:0]      r_oldest;
    logic [CW-1:0]      r_cnt;
    logic [LVL_W-1:0]   r_frac;
    logic [31:0]        r_prod;
    t_res               r_res;
    logic               r_ovalid;
    t_res               r_out;

    logic [RW-1:0]      ram_rdata;
    logic [RW-1:0]      ram_wdata;
    logic               ram_we;
    t_voice             rec_rd;
    logic [VW-1:0]      age_rd;
    logic               slot_free;
    logic               last_v;

    // envelope step signals
    logic [LEN_W-1:0]   dlen;
    logic [LEN_W-1:0]   rlen;
    logic [LEN_W-1:0]   len_sel;
    logic [LEN_W:0]     num;
    logic [LEN_W:0]     c1;
    logic               skip_div;
    logic               div_start;
    logic               div_done;
    logic [FRAC_W-1:0]  div_quot;
    logic [16:0]        mul_b;
    logic [31:0]        prod;
    t_voice             tk_rec;
    logic [LVL_W-1:0]   tk_lvl;
    t_voice             tr_rec;
    logic [VW-1:0]      tr_age;
    logic [LVL_W-1:0]   vel_sat;
    logic               rl_hit;
    t_voice             rl_rec;
    logic [CW-1:0]      rl_sum;
    logic [4:0]         rl_sat;
    logic               sc_stop;
    t_voice             w_rec;
    logic [VW-1:0]      w_age;

    vpe_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_VOICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_v),
        .i_wdata (ram_wdata),
        .i_raddr (r_v),
        .o_rdata (ram_rdata)
    );

    vpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num[LEN_W-1:0]),
        .i_den   (len_sel),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // never written entries read as the reset voice
    always_comb begin
        if (r_vld[r_v]) begin
            rec_rd = t_voice'(ram_rdata[$bits(t_voice)-1:0]);
            age_rd = ram_rdata[RW-1:$bits(t_voice)];
        end else begin
            rec_rd = '{stage: ST_STOPPED, default: '0};
            age_rd = r_v;
        end
    end

    assign slot_free = !r_ovalid || i_ready;
    assign last_v    = r_v == LAST_V;

    // divider operands for the current stage
    assign dlen = (i_cfg.decay_len == '0) ? LEN_W'(1) : i_cfg.decay_len;
    assign rlen = (i_cfg.rel_len == '0) ? LEN_W'(1) : i_cfg.rel_len;

    always_comb begin
        unique case (r_rec.stage)
            ST_ATTACK: begin
                len_sel = i_cfg.attack_len;
                num     = {1'b0, r_rec.count} + 21'd1;
            end
            ST_DECAY: begin
                len_sel = dlen;
                num     = {1'b0, r_rec.count};
            end
            default: begin
                len_sel = rlen;
                num     = {1'b0, r_rec.count};
            end
        endcase
    end

    assign skip_div = (r_rec.stage == ST_STOPPED)
                   || (r_rec.stage == ST_ATTACK && i_cfg.attack_len == '0)
                   || (num >= {1'b0, len_sel});
    assign div_start = (r_state == S_CALC) && (r_pass == PASS_TICK) && !skip_div;

    // release scaling
    assign mul_b = 17'h08000 - {1'b0, r_frac};
    assign prod  = 32'(r_rec.rstart) * 32'(mul_b);

    // one envelope step
    assign c1 = {1'b0, r_rec.count} + 21'd1;

    always_comb begin
        tk_rec = r_rec;
        tk_lvl = '0;
        unique case (r_rec.stage)
            ST_STOPPED: begin
                tk_lvl = '0;
            end
            ST_ATTACK: begin
                if (i_cfg.attack_len == '0) begin
                    tk_rec.stage = ST_DECAY;
                    tk_rec.count = '0;
                    tk_lvl       = FULL_LEVEL;
                end else if (c1 >= {1'b0, i_cfg.attack_len}) begin
                    tk_rec.stage = ST_DECAY;
                    tk_rec.count = '0;
                    tk_lvl       = FULL_LEVEL;
                end else begin
                    tk_rec.count = c1[LEN_W-1:0];
                    tk_lvl       = r_frac;
                end
            end
            ST_DECAY: begin
                tk_lvl       = FULL_LEVEL - r_frac;
                tk_rec.count = c1[LEN_W-1:0];
                if (c1 >= {1'b0, dlen}) begin
                    tk_rec.stage = ST_STOPPED;
                end
            end
            ST_RELEASE: begin
                tk_lvl       = r_prod[30:15];
                tk_rec.count = c1[LEN_W-1:0];
                if (c1 >= {1'b0, rlen}) begin
                    tk_rec.stage = ST_STOPPED;
                end
            end
        endcase
        if (tk_lvl == '0) begin
            tk_rec.stage = ST_STOPPED;
        end
        tk_rec.level = (tk_rec.stage == ST_STOPPED) ? '0 : tk_lvl;
    end

    // trigger write: new voice or rank shift
    assign vel_sat = (r_cmd.vel > FULL_LEVEL) ? FULL_LEVEL : r_cmd.vel;

    always_comb begin
        tr_rec = r_rec;
        tr_age = (r_age > r_old) ? r_age - VW'(1) : r_age;
        if (r_v == r_sel) begin
            tr_rec.stage  = (i_cfg.attack_len != '0) ? ST_ATTACK : ST_DECAY;
            tr_rec.count  = '0;
            tr_rec.level  = (i_cfg.attack_len != '0) ? '0 : FULL_LEVEL;
            tr_rec.rstart = '0;
            tr_rec.note   = r_cmd.note;
            tr_rec.vel    = vel_sat;
            tr_age        = LAST_V;
        end
    end

    // release match
    assign rl_hit = (r_rec.stage != ST_STOPPED) && (r_rec.stage != ST_RELEASE)
                 && (r_rec.note == r_cmd.note);
    always_comb begin
        rl_rec = r_rec;
        if (rl_hit) begin
            rl_rec.rstart = r_rec.level;
            rl_rec.count  = '0;
            rl_rec.stage  = ST_RELEASE;
        end
    end
    assign rl_sum = r_cnt + CW'(rl_hit);
    assign rl_sat = (32'(rl_sum) > 32'd31) ? 5'd31 : 5'(rl_sum);

    assign sc_stop = r_rec.stage == ST_STOPPED;

    // write-back selection
    always_comb begin
        unique case (r_pass)
            PASS_TICK: begin
                w_rec = tk_rec;
                w_age = r_age;
            end
            PASS_TRIG: begin
                w_rec = tr_rec;
                w_age = tr_age;
            end
            default: begin
                w_rec = rl_rec;
                w_age = r_age;
            end
        endcase
    end

    assign ram_we    = (r_state == S_WR) && (r_pass != PASS_SCAN);
    assign ram_wdata = {w_age, w_rec};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_cmd_valid) n_state = S_RD;
            S_RD:   n_state = S_DAT;
            S_DAT:  n_state = S_CALC;
            S_CALC: begin
                if (r_pass != PASS_TICK) begin
                    n_state = S_WR;
                end else if (skip_div) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:  if (div_done) n_state = S_MUL;
            S_MUL:  n_state = S_WR;
            S_WR: begin
                priority if (r_pass == PASS_TICK && r_v <= REP_LAST) begin
                    n_state = S_EMIT;
                end else if (!last_v) begin
                    n_state = S_RD;
                end else if (r_pass == PASS_TICK) begin
                    n_state = S_IDLE;
                end else if (r_pass == PASS_SCAN) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = (r_pass == PASS_TICK && !last_v) ? S_RD : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop = (r_state == S_IDLE) && i_cmd_valid;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pass   <= PASS_TICK;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                unique case (i_cmd.kind)
                    REQ_TRIG: r_pass <= PASS_SCAN;
                    REQ_REL:  r_pass <= PASS_REL;
                    default:  r_pass <= PASS_TICK;
                endcase
            end else if (r_state == S_WR && r_pass == PASS_SCAN && last_v) begin
                r_pass <= PASS_TRIG;
            end
            if (ram_we) begin
                r_vld[r_v] <= 1'b1;
            end
            if (r_state == S_EMIT && slot_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd    <= i_cmd;
                    r_v      <= '0;
                    r_found  <= 1'b0;
                    r_cnt    <= '0;
                    r_oldest <= '0;
                end
            end
            S_DAT: begin
                r_rec <= rec_rd;
                r_age <= age_rd;
            end
            S_CALC: begin
                r_frac <= FULL_LEVEL;
            end
            S_DIV: begin
                if (div_done) begin
                    r_frac <= {1'b0, div_quot};
                end
            end
            S_MUL: begin
                r_prod <= prod;
            end
            S_WR: begin
                unique case (r_pass)
                    PASS_SCAN: begin
                        if (!r_found && sc_stop) begin
                            r_found <= 1'b1;
                            r_sel   <= r_v;
                            r_old   <= r_age;
                        end
                        if (r_age == '0) begin
                            r_oldest <= r_v;
                        end
                        if (last_v && !r_found && !sc_stop) begin
                            r_sel <= (r_age == '0) ? r_v : r_oldest;
                            r_old <= '0;
                        end
                    end
                    PASS_TRIG: begin
                        if (r_v == r_sel) begin
                            r_res <= '{idx: 4'(r_v), act: 1'b1, note: r_cmd.note,
                                       vel: vel_sat, level: tr_rec.level,
                                       rcnt: '0, last: 1'b1};
                        end
                    end
                    PASS_REL: begin
                        r_cnt <= rl_sum;
                        r_res <= '{idx: '0, act: 1'b0, note: r_cmd.note, vel: '0,
                                   level: '0, rcnt: rl_sat, last: 1'b1};
                    end
                    default: begin
                        r_res <= '{idx: 4'(r_v), act: tk_rec.stage != ST_STOPPED,
                                   note: r_rec.note, vel: r_rec.vel,
                                   level: tk_rec.level, rcnt: '0,
                                   last: r_v == REP_LAST};
                    end
                endcase
                if (r_pass == PASS_SCAN && last_v) begin
                    r_v <= '0;
                end else if (!last_v && !(r_pass == PASS_TICK && r_v <= REP_LAST)) begin
                    r_v <= r_v + VW'(1);
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    r_out <= r_res;
                    if (r_pass == PASS_TICK && !last_v) begin
                        r_v <= r_v + VW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_out;

    // checks
    a_div_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_pass == PASS_TICK))
        else $error("divider in use outside a tick pass");

    a_done_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished while not awaited");

    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_RD))
        else $error("command taken without starting a pass");

    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside the emit state");

    a_trig_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_pass == PASS_TRIG) |-> r_res.act)
        else $error("trigger result shows an inactive voice");

endmodule
